[hw/rtl/ams_pkg.sv]
package ams_pkg;

  typedef struct packed {
    logic [3:0]         channel;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] travel;
    logic signed [31:0] start_speed;
    logic signed [31:0] accel;
    logic               prefer_longer;
  } ams_req_t;

  typedef struct packed {
    logic [3:0]         channel_out;
    logic [1:0]         outcome;
    logic [30:0]        frames;
    logic signed [31:0] delta_x;
    logic signed [31:0] delta_y;
    logic signed [31:0] delta_z;
    logic signed [15:0] unit_x;
    logic signed [15:0] unit_y;
    logic signed [15:0] unit_z;
  } ams_rsp_t;

  localparam logic [1:0] OutStart = 2'd0;
  localparam logic [1:0] OutMove  = 2'd1;
  localparam logic [1:0] OutClear = 2'd2;
  localparam logic [1:0] OutDegen = 2'd3;

  localparam int unsigned SqrtSteps = 16;
  localparam int unsigned DivSteps  = 32;

  // one restoring square root step: one result bit per step, two input bits from the top
  typedef struct packed {
    logic [31:0] rem;
    logic [15:0] root;
  } sqrt_st_t;

  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, logic [31:0] v, int unsigned k);
    sqrt_st_t o;
    logic [33:0] r2;
    logic [33:0] trial;
    r2    = {s.rem, v[2*k+1 -: 2]};
    trial = {16'd0, s.root, 2'b01};
    o = s;
    if (r2 >= trial) begin
      o.rem  = 32'(r2 - trial);
      o.root = {s.root[14:0], 1'b1};
    end else begin
      o.rem  = 32'(r2);
      o.root = {s.root[14:0], 1'b0};
    end
    return o;
  endfunction

  // one restoring division step on magnitudes
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] quo;
  } div_st_t;

  function automatic div_st_t div_step(div_st_t s, logic [31:0] n, logic [31:0] d,
                                       int unsigned k);
    div_st_t o;
    logic [32:0] r2;
    r2 = {s.rem, n[k]};
    o = s;
    if (r2 >= {1'b0, d}) begin
      o.rem    = 32'(r2 - {1'b0, d});
      o.quo[k] = 1'b1;
    end else begin
      o.rem    = 32'(r2);
      o.quo[k] = 1'b0;
    end
    return o;
  endfunction

  function automatic logic [31:0] mag(logic signed [31:0] x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction

endpackage

[hw/rtl/ams_sqrt.sv]
// pipelined floor square root of a 32-bit unsigned value, one bit pair per stage
module ams_sqrt (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [31:0]              val_i,
  output logic [15:0]              root_o
);
  import ams_pkg::*;

  sqrt_st_t    st_q [SqrtSteps];
  logic [31:0] v_q  [SqrtSteps];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= sqrt_step('0, val_i, SqrtSteps - 1);
      v_q[0]  <= val_i;
      for (int unsigned k = 1; k < SqrtSteps; k++) begin
        st_q[k] <= sqrt_step(st_q[k-1], v_q[k-1], SqrtSteps - 1 - k);
        v_q[k]  <= v_q[k-1];
      end
    end
  end

  assign root_o = st_q[SqrtSteps-1].root;
endmodule

[hw/rtl/ams_div.sv]
// pipelined truncating signed divider, one quotient bit per stage
// a zero divisor gives a meaningless quotient, the caller masks it
module ams_div (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [31:0]       num_i,
  input  logic signed [31:0]       den_i,
  output logic signed [31:0]       quo_o
);
  import ams_pkg::*;

  div_st_t     st_q [DivSteps];
  logic [31:0] n_q  [DivSteps];
  logic [31:0] d_q  [DivSteps];
  logic        neg_q [DivSteps];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0]  <= div_step('0, mag(num_i), mag(den_i), DivSteps - 1);
      n_q[0]   <= mag(num_i);
      d_q[0]   <= mag(den_i);
      neg_q[0] <= num_i[31] ^ den_i[31];
      for (int unsigned k = 1; k < DivSteps; k++) begin
        st_q[k]  <= div_step(st_q[k-1], n_q[k-1], d_q[k-1], DivSteps - 1 - k);
        n_q[k]   <= n_q[k-1];
        d_q[k]   <= d_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  // min / -1 wraps naturally: magnitude 2^31 negated stays 2^31
  assign quo_o = neg_q[DivSteps-1] ? 32'(-st_q[DivSteps-1].quo) : st_q[DivSteps-1].quo;
endmodule

[hw/rtl/accelerated_motion_setup.sv]
// channel   direction  payload     handshake
// req       in         ams_req_t   req_valid_i / req_ready_o
// rsp       out        ams_rsp_t   rsp_valid_o / rsp_ready_i
//
// one request per cycle sustained while the output register is free or taken; a request
// passes the input register, 16 root stages, 32 divider stages, decision register,
// 16 delay stages, 1 register, 32 unit vector divider stages, output register.
// the discriminant root runs alongside the length root.
// reset clears only the valid bits. all stages advance together when the output
// register is free or taken; a stall freezes the whole pipe, nothing lost or doubled.
module accelerated_motion_setup (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  ams_pkg::ams_req_t req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output ams_pkg::ams_rsp_t rsp_o
);
  import ams_pkg::*;

  localparam int unsigned Lat = 1 + SqrtSteps + DivSteps + 1 + SqrtSteps + 1 + DivSteps;

  logic adv;
  assign adv         = !rsp_valid_o || rsp_ready_i;
  assign req_ready_o = adv;

  // valid bits and request copies travel along the pipe
  logic     vld_q [Lat];
  ams_req_t req_q [Lat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned k = 0; k < Lat; k++) vld_q[k] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= req_valid_i;
      for (int unsigned k = 1; k < Lat; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      req_q[0] <= req_i;
      for (int unsigned k = 1; k < Lat; k++) req_q[k] <= req_q[k-1];
    end
  end

  // stage 0: squared length and discriminant products
  logic signed [31:0] sq_q, mxp_q, myp_q, mzp_q, disc_q, dmv_q, dsh_q;
  logic signed [31:0] v256, v16;
  assign v256 = req_i.start_speed / 256;
  assign v16  = req_i.start_speed / 16;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q  <= 32'(req_i.dir_x * req_i.dir_x) + 32'(req_i.dir_y * req_i.dir_y)
             + 32'(req_i.dir_z * req_i.dir_z);
      mxp_q <= 32'(req_i.dir_x * req_i.travel);
      myp_q <= 32'(req_i.dir_y * req_i.travel);
      mzp_q <= 32'(req_i.dir_z * req_i.travel);
      disc_q <= 32'(v256 * v16) + 32'(32'(req_i.accel * 32'(req_i.travel)) <<< 5);
      dmv_q <= 32'(32'(req_i.travel) * req_i.start_speed);
      dsh_q <= 32'(32'(req_i.travel) <<< 16);
    end
  end

  // stage 1..16: length root; discriminant root runs alongside
  logic [15:0] len_w, droot_w;
  ams_sqrt u_len (.clk_i, .en_i(adv), .val_i(sq_q), .root_o(len_w));
  ams_sqrt u_dsq (.clk_i, .en_i(adv),
                  .val_i(disc_q[31] || disc_q == 0 ? 32'd0 : disc_q), .root_o(droot_w));

  // delay side products to line up with the root outputs
  typedef struct packed {
    logic signed [31:0] mx, my, mz, dmv, dsh;
  } side_t;
  side_t side_q [SqrtSteps];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= '{mx: mxp_q, my: myp_q, mz: mzp_q, dmv: dmv_q, dsh: dsh_q};
      for (int unsigned k = 1; k < SqrtSteps; k++) side_q[k] <= side_q[k-1];
    end
  end

  localparam int unsigned PA = SqrtSteps;  // request index at root output
  logic signed [31:0] len_s, root6;
  assign len_s = 32'({16'd0, len_w});
  assign root6 = 32'({16'd0, droot_w}) <<< 6;

  // first divider rank: displacements, constant duration, two roots
  logic signed [31:0] qx, qy, qz, qd, qr1, qr2;
  logic signed [31:0] vv, aa, n1, n2, dd;
  assign vv = req_q[PA].start_speed;
  assign aa = req_q[PA].accel;
  assign n1 = root6 - vv;
  assign n2 = -(vv + root6);
  assign dd = side_q[SqrtSteps-1].dsh;
  ams_div u_dx (.clk_i, .en_i(adv), .num_i(side_q[SqrtSteps-1].mx), .den_i(len_s), .quo_o(qx));
  ams_div u_dy (.clk_i, .en_i(adv), .num_i(side_q[SqrtSteps-1].my), .den_i(len_s), .quo_o(qy));
  ams_div u_dz (.clk_i, .en_i(adv), .num_i(side_q[SqrtSteps-1].mz), .den_i(len_s), .quo_o(qz));
  ams_div u_dc (.clk_i, .en_i(adv), .num_i(dd), .den_i(vv), .quo_o(qd));
  ams_div u_r1 (.clk_i, .en_i(adv), .num_i(n1), .den_i(aa), .quo_o(qr1));
  ams_div u_r2 (.clk_i, .en_i(adv), .num_i(n2), .den_i(aa), .quo_o(qr2));

  // carry length and sign info through the divider
  typedef struct packed {
    logic [15:0] len;
    logic        neg;
  } lmeta_t;
  lmeta_t lm_q [DivSteps];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      lm_q[0] <= '{len: len_w, neg: side_q[SqrtSteps-1].dmv[31]};
      for (int unsigned k = 1; k < DivSteps; k++) lm_q[k] <= lm_q[k-1];
    end
  end

  // decision stage
  localparam int unsigned PB = PA + DivSteps;
  typedef struct packed {
    logic [1:0]         oc;
    logic signed [31:0] dur, mx, my, mz;
    logic [15:0]        len;
  } dec_t;
  dec_t dec_d, dec_q;
  always_comb begin
    logic signed [31:0] big, sml;
    big = (qr1 >= qr2) ? qr1 : qr2;
    sml = (qr1 >= qr2) ? qr2 : qr1;
    dec_d     = '0;
    dec_d.oc  = OutDegen;
    dec_d.len = lm_q[DivSteps-1].len;
    dec_d.mx  = qx;
    dec_d.my  = qy;
    dec_d.mz  = qz;
    if (lm_q[DivSteps-1].len != 0) begin
      if (req_q[PB].accel == 0) begin
        if (lm_q[DivSteps-1].neg) dec_d.oc = OutMove;
        else if (req_q[PB].start_speed != 0) begin
          dec_d.oc  = OutStart;
          dec_d.dur = qd;
        end
      end else begin
        dec_d.dur = req_q[PB].prefer_longer ? big : sml;
        dec_d.oc  = (dec_d.dur[31] || dec_d.dur == 0) ? OutClear : OutStart;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) dec_q <= dec_d;
  end

  // second sqrt-length delay slot then unit vector divides
  localparam int unsigned PC = PB + 1;
  dec_t dec2_q [SqrtSteps];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dec2_q[0] <= dec_q;
      for (int unsigned k = 1; k < SqrtSteps; k++) dec2_q[k] <= dec2_q[k-1];
    end
  end

  localparam int unsigned PD = PC + SqrtSteps;
  dec_t dec3_q;
  always_ff @(posedge clk_i) begin
    if (adv) dec3_q <= dec2_q[SqrtSteps-1];
  end

  localparam int unsigned PE = PD + 1;
  logic signed [31:0] ulen, ux, uy, uz;
  assign ulen = 32'({16'd0, dec3_q.len});
  ams_div u_ux (.clk_i, .en_i(adv), .num_i(32'(req_q[PE].dir_x) <<< 14), .den_i(ulen), .quo_o(ux));
  ams_div u_uy (.clk_i, .en_i(adv), .num_i(32'(req_q[PE].dir_y) <<< 14), .den_i(ulen), .quo_o(uy));
  ams_div u_uz (.clk_i, .en_i(adv), .num_i(32'(req_q[PE].dir_z) <<< 14), .den_i(ulen), .quo_o(uz));

  dec_t dec4_q [DivSteps];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dec4_q[0] <= dec3_q;
      for (int unsigned k = 1; k < DivSteps; k++) dec4_q[k] <= dec4_q[k-1];
    end
  end

  // output register
  ams_rsp_t rsp_d, rsp_q;
  logic     out_vld_q;
  dec_t     fin;
  assign fin = dec4_q[DivSteps-1];
  always_comb begin
    logic mv;
    mv = (fin.oc == OutMove) || (fin.oc == OutClear);
    rsp_d             = '0;
    rsp_d.channel_out = req_q[Lat-1].channel;
    rsp_d.outcome     = fin.oc;
    if (fin.oc == OutStart) begin
      rsp_d.frames = fin.dur[30:0];
      rsp_d.unit_x = ux[15:0];
      rsp_d.unit_y = uy[15:0];
      rsp_d.unit_z = uz[15:0];
    end
    if (mv) begin
      rsp_d.delta_x = fin.mx;
      rsp_d.delta_y = fin.my;
      rsp_d.delta_z = fin.mz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (adv) out_vld_q <= vld_q[Lat-1];
  end
  always_ff @(posedge clk_i) begin
    if (adv) rsp_q <= rsp_d;
  end

  assign rsp_valid_o = out_vld_q;
  assign rsp_o       = rsp_q;
endmodule

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ams_pkg::*;

  // depth of the design's request pipe
  localparam int unsigned PipeDepth = 99;
  localparam int unsigned NumRandom = 600;

  logic     clk;
  logic     rst_n;
  logic     req_valid;
  logic     req_ready;
  ams_req_t req;
  logic     rsp_valid;
  logic     rsp_ready;
  ams_rsp_t rsp;

  accelerated_motion_setup u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_valid_i(req_valid),
    .req_ready_o(req_ready),
    .req_i      (req),
    .rsp_valid_o(rsp_valid),
    .rsp_ready_i(rsp_ready),
    .rsp_o      (rsp)
  );

  // floor square root of an unsigned 32-bit value
  function automatic logic [31:0] floor_sqrt(logic [31:0] v);
    logic [31:0] r;
    logic [31:0] b;
    r = 0;
    b = 32'h4000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // truncating divide, most negative over -1 wraps to itself
  function automatic logic signed [31:0] sdiv(logic signed [31:0] n, logic signed [31:0] d);
    if (n == 32'sh8000_0000 && d == -32'sd1) return n;
    return n / d;
  endfunction

  // expected response for one motion request
  function automatic ams_rsp_t motion_setup(ams_req_t q);
    ams_rsp_t o;
    logic signed [31:0] dx, dy, dz, d, v, a, sq, len, dur, disc, root, r1, r2;
    logic signed [31:0] mx, my, mz, ux, uy, uz;
    logic [1:0] oc;
    dx = q.dir_x;
    dy = q.dir_y;
    dz = q.dir_z;
    d = q.travel;
    v = q.start_speed;
    a = q.accel;
    sq = dx * dx + dy * dy + dz * dz;
    len = floor_sqrt(sq);
    oc = OutDegen;
    dur = 0;
    mx = 0; my = 0; mz = 0; ux = 0; uy = 0; uz = 0;
    if (len != 0) begin
      mx = sdiv(dx * d, len);
      my = sdiv(dy * d, len);
      mz = sdiv(dz * d, len);
      if (a == 0) begin
        if ($signed(d * v) < 0) oc = OutMove;
        else if (v != 0) begin
          dur = sdiv(d <<< 16, v);
          oc = OutStart;
        end
      end else begin
        disc = sdiv(v, 256) * sdiv(v, 16) + ((a * d) <<< 5);
        root = 0;
        if (disc > 0) root = floor_sqrt(disc) << 6;
        r1 = sdiv(root - v, a);
        r2 = sdiv(-(v + root), a);
        if (q.prefer_longer) dur = (r1 >= r2) ? r1 : r2;
        else dur = (r1 >= r2) ? r2 : r1;
        oc = (dur <= 0) ? OutClear : OutStart;
      end
      if (oc == OutStart) begin
        ux = sdiv(dx <<< 14, len);
        uy = sdiv(dy <<< 14, len);
        uz = sdiv(dz <<< 14, len);
      end
    end
    if (oc != OutMove && oc != OutClear) begin
      mx = 0; my = 0; mz = 0;
    end
    if (oc != OutStart) dur = 0;
    o.channel_out = q.channel;
    o.outcome = oc;
    o.frames = dur[30:0];
    o.delta_x = mx;
    o.delta_y = my;
    o.delta_z = mz;
    o.unit_x = ux[15:0];
    o.unit_y = uy[15:0];
    o.unit_z = uz[15:0];
    return o;
  endfunction

  class motion_scoreboard;
    ams_rsp_t pending[$];
    int unsigned errors = 0;

    function void note_request(ams_req_t q);
      pending.push_back(motion_setup(q));
    endfunction

    function void check_response(ams_rsp_t got);
      ams_rsp_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: exp ch=%0d oc=%0d fr=%0d d=%0d,%0d,%0d u=%0d,%0d,%0d",
                   want.channel_out, want.outcome, want.frames, want.delta_x,
                   want.delta_y, want.delta_z, want.unit_x, want.unit_y, want.unit_z);
          $display("          got ch=%0d oc=%0d fr=%0d d=%0d,%0d,%0d u=%0d,%0d,%0d",
                   got.channel_out, got.outcome, got.frames, got.delta_x,
                   got.delta_y, got.delta_z, got.unit_x, got.unit_y, got.unit_z);
        end
      end
    endfunction
  endclass

  motion_scoreboard sb;
  bit calm;       // no idling on either side while set
  bit hold_off;   // receiver stalls completely while set

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #100us;
    $display("TB_ERROR");
    $finish;
  end

  // random wide values with emphasis on extremes
  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 0;
      3: return $urandom_range(0, 4000) - 2000;
      4: return ($urandom_range(0, 65535) - 32768) <<< 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return '0;
      3: return 16'($urandom_range(0, 200) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic ams_req_t random_request();
    ams_req_t q;
    q.channel = 4'($urandom);
    q.dir_x = pick16();
    q.dir_y = pick16();
    q.dir_z = pick16();
    q.travel = pick16();
    q.start_speed = pick32();
    q.accel = ($urandom_range(0, 2) == 0) ? 32'd0 : pick32();
    q.prefer_longer = 1'($urandom);
    return q;
  endfunction

  // offer one request and wait for acceptance
  task automatic send_request(ams_req_t q);
    while (!calm && $urandom_range(0, 99) < 14) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req <= q;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    sb.note_request(q);
    @(negedge clk);
  endtask

  function automatic ams_req_t make_req(logic [3:0] ch, logic [15:0] x, logic [15:0] y,
                                        logic [15:0] z, logic [15:0] d, logic [31:0] v,
                                        logic [31:0] a, logic lg);
    ams_req_t q;
    q.channel = ch; q.dir_x = x; q.dir_y = y; q.dir_z = z;
    q.travel = d; q.start_speed = v; q.accel = a; q.prefer_longer = lg;
    return q;
  endfunction

  // receiver: random stalls, calm stretch, one long hold-off
  always @(negedge clk) begin
    if (hold_off) rsp_ready <= 1'b0;
    else if (calm) rsp_ready <= 1'b1;
    else rsp_ready <= ($urandom_range(0, 99) >= 14);
  end

  always @(posedge clk) begin
    if (rst_n && rsp_valid && rsp_ready) sb.check_response(rsp);
  end

  initial begin
    int unsigned n;
    sb = new();
    calm = 0;
    hold_off = 0;
    rst_n = 0;
    req_valid = 0;
    rsp_ready = 0;
    req = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed cases
    send_request(make_req(4'd0, 0, 0, 0, 16'd100, 32'd256, 0, 0));          // zero length
    send_request(make_req(4'd1, 16'd3, 16'd4, 0, 16'd10, 0, 0, 0));         // zero speed
    send_request(make_req(4'd2, 16'd3, 16'd4, 0, 16'd10, 32'd512, 0, 1));   // start
    send_request(make_req(4'd3, 16'd3, 16'd4, 0, 16'd10, -32'sd512, 0, 0)); // move now
    send_request(make_req(4'd4, 16'd1, 0, 0, 16'h8000, -32'sd1, 0, 0));
    send_request(make_req(4'd5, 16'd1, 0, 0, 16'h8000, 32'd1, 0, 0));       // move now
    send_request(make_req(4'd6, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF,
                          32'h7FFF_FFFF, 0, 0));                            // big square
    send_request(make_req(4'd7, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000,
                          32'h8000_0000, 32'h8000_0000, 1));
    send_request(make_req(4'd8, 16'd1, 16'd1, 16'd1, 16'd100, 32'd256, 32'd16, 1));
    send_request(make_req(4'd9, 16'd1, 16'd1, 16'd1, 16'd100, 32'd256, 32'd16, 0));
    send_request(make_req(4'd10, 16'd0, 16'd5, 0, 16'd100, 32'd2560, -32'sd64, 1));
    send_request(make_req(4'd11, 16'd0, 16'd5, 0, 16'd100, 32'd2560, -32'sd64, 0));
    send_request(make_req(4'd12, 16'd2, 0, 0, 16'd0, 32'd0, 32'd1, 1));
    send_request(make_req(4'd13, 16'h8000, 0, 0, 16'h8000, 32'h8000_0000, -32'sd1, 0));
    send_request(make_req(4'd14, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 32'hFFFF_FFFF,
                          32'h7FFF_FFFF, 1));
    send_request(make_req(4'd15, 16'h7FFF, 0, 0, 16'h7FFF, 32'd1, 0, 1));

    // random traffic with a calm stretch and one long receiver hold-off
    for (n = 0; n < NumRandom; n++) begin
      if (n == 150) calm = 1;
      if (n == 250) calm = 0;
      if (n == 350) begin
        fork
          begin
            hold_off = 1;
            repeat (400) @(negedge clk);
            hold_off = 0;
          end
        join_none
      end
      send_request(random_request());
    end
    req_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PipeDepth + 20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

[accelerated_motion_setup.f]
hw/rtl/ams_pkg.sv
hw/rtl/ams_sqrt.sv
hw/rtl/ams_div.sv
hw/rtl/accelerated_motion_setup.sv
tb/testbench.sv
